>>> rtl/sst_pkg.sv
`default_nettype none

package sst_pkg;

   // Field widths of one request and one result
   localparam int OpW     = 2;
   localparam int KeyW    = 16;
   localparam int ScoreW  = 31;
   localparam int RangeW  = 6;
   localparam int StatW   = 2;
   localparam int RankW   = 5;
   localparam int CountW  = 6;

   // Most results one range read may produce
   localparam int MaxOut  = 32;

   // Request opcodes
   localparam logic [OpW-1:0] OpAdd    = 2'd0;
   localparam logic [OpW-1:0] OpRemove = 2'd1;
   localparam logic [OpW-1:0] OpRange  = 2'd2;

   // Result status codes
   localparam logic [StatW-1:0] StOk       = 2'd0;
   localparam logic [StatW-1:0] StFull     = 2'd1;
   localparam logic [StatW-1:0] StNotFound = 2'd2;
   localparam logic [StatW-1:0] StEmpty    = 2'd3;

   // One table row
   typedef struct packed {
      logic [KeyW-1:0]   key;
      logic [ScoreW-1:0] score;
   } entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_UP,
      S_DOWN,
      S_FINISH,
      S_RD_ISSUE,
      S_RD_LOAD
   } state_type;

endpackage

`default_nettype wire

>>> rtl/sst_if.sv
`default_nettype none

// Request channel: one table operation
interface sst_req_if;
   logic                          valid;
   logic                          ready;
   logic [sst_pkg::OpW-1:0]       opcode;
   logic [sst_pkg::KeyW-1:0]      key;
   logic [sst_pkg::ScoreW-1:0]    score;
   logic [sst_pkg::RangeW-1:0]    range_first;
   logic [sst_pkg::RangeW-1:0]    range_end;

   modport source (output valid, output opcode, output key, output score,
                   output range_first, output range_end, input ready);
   modport sink   (input valid, input opcode, input key, input score,
                   input range_first, input range_end, output ready);
endinterface

// Response channel: one reported entry or status
interface sst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sst_pkg::StatW-1:0]     status;
   logic [sst_pkg::KeyW-1:0]      entry_key;
   logic [sst_pkg::ScoreW-1:0]    entry_score;
   logic [sst_pkg::RankW-1:0]     rank;
   logic [sst_pkg::CountW-1:0]    entry_count;
   logic                          was_present;
   logic                          last;

   modport source (output valid, output status, output entry_key, output entry_score,
                   output rank, output entry_count, output was_present, output last,
                   input ready);
   modport sink   (input valid, input status, input entry_key, input entry_score,
                   input rank, input entry_count, input was_present, input last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/sorted_score_table.sv
`default_nettype none

// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    opcode, key, score, range_first, range_end
// rsp_ch    out        valid/ready    status, entry_key, entry_score, rank,
//                                     entry_count, was_present, last
//
// Add and remove first search for the key, reading one row a cycle from the
// entry memory; then one compare unit walks the entry up or down, or closes
// the gap, one row a cycle.
// A range read does a memory read, then an output load, for each result.
// Synchronous reset clears the entry count; memory contents are not cleared.
// A stalled response holds its register and the sequencer waits on it; a new
// request is taken as soon as the sequencer is idle, even with a response held.

module sorted_score_table #(
   parameter int CAPACITY = 32
) (
   input  wire           clock,
   input  wire           reset,
   sst_req_if.sink       req_ch,
   sst_rsp_if.source     rsp_ch
);

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int PW   = CntW + 1;
   localparam int RW   = ((CntW > sst_pkg::RangeW) ? CntW : sst_pkg::RangeW) + 2;

   // Entry memory
   sst_pkg::entry_type entry_mem [CAPACITY];
   sst_pkg::entry_type rd_data_ff;
   logic               rd_en;
   logic [IdxW-1:0]    rd_addr;
   logic               wr_en;
   logic [IdxW-1:0]    wr_addr;
   sst_pkg::entry_type wr_data;

   // Sequencer state
   sst_pkg::state_type             state_ff, state_in;
   logic [sst_pkg::OpW-1:0]        op_ff, op_in;
   logic [sst_pkg::KeyW-1:0]       key_ff, key_in;
   logic [sst_pkg::ScoreW-1:0]     score_ff, score_in;
   logic [CntW-1:0]                pos_ff, pos_in;
   logic [CntW-1:0]                idx_ff, idx_in;
   logic [CntW-1:0]                stop_ff, stop_in;
   logic [CntW-1:0]                fill_ff, fill_in;
   logic                           look_ff, look_in;

   // Staged single result
   logic [sst_pkg::StatW-1:0]      res_status_ff, res_status_in;
   logic [sst_pkg::ScoreW-1:0]     res_score_ff, res_score_in;
   logic [CntW-1:0]                res_rank_ff, res_rank_in;
   logic                           res_was_ff, res_was_in;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sst_pkg::StatW-1:0]      rsp_status_ff, rsp_status_in;
   logic [sst_pkg::KeyW-1:0]       rsp_key_ff, rsp_key_in;
   logic [sst_pkg::ScoreW-1:0]     rsp_score_ff, rsp_score_in;
   logic [sst_pkg::RankW-1:0]      rsp_rank_ff, rsp_rank_in;
   logic [sst_pkg::CountW-1:0]     rsp_count_ff, rsp_count_in;
   logic                           rsp_was_ff, rsp_was_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic            accept;
   logic            out_free;
   logic            hit;
   logic            move;
   logic [PW-1:0]   pos_up1;
   logic [PW-1:0]   pos_up2;
   logic [PW-1:0]   idx_up1;
   logic [PW-1:0]   fill_w;
   logic [CntW-1:0] pos_dn1;
   logic [CntW-1:0] pos_dn2;
   logic [CntW-1:0] idx_dn1;
   logic [RW-1:0]   fill_r;
   logic [RW-1:0]   first_r;
   logic [RW-1:0]   end_r;
   logic [RW-1:0]   start_r;
   logic [RW-1:0]   lim_r;
   logic [RW-1:0]   stop_r;
   logic            range_empty;

   assign req_ch.ready = (state_ff == sst_pkg::S_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Neighbor positions
   assign pos_up1 = PW'(pos_ff) + PW'(1);
   assign pos_up2 = PW'(pos_ff) + PW'(2);
   assign idx_up1 = PW'(idx_ff) + PW'(1);
   assign fill_w  = PW'(fill_ff);
   assign pos_dn1 = pos_ff - CntW'(1);
   assign pos_dn2 = pos_ff - CntW'(2);
   assign idx_dn1 = idx_ff - CntW'(1);

   // Clip the requested range to the held entries and to at most MaxOut results
   assign fill_r  = RW'(fill_ff);
   assign first_r = RW'(req_ch.range_first);
   assign end_r   = RW'(req_ch.range_end);
   assign start_r = (first_r < fill_r - RW'(1)) ? first_r : fill_r - RW'(1);
   assign lim_r   = start_r + RW'(sst_pkg::MaxOut);
   always_comb begin
      stop_r = (end_r < fill_r) ? end_r : fill_r;
      if (lim_r < stop_r) begin
         stop_r = lim_r;
      end
   end
   assign range_empty = (fill_ff == '0) || (start_r >= stop_r);

   // Compare unit
   assign hit  = look_ff && (rd_data_ff.key == key_ff);
   assign move = (op_ff == sst_pkg::OpRemove) || (score_ff < rd_data_ff.score);

   // Next state and memory control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      score_in      = score_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      fill_in       = fill_ff;
      look_in       = look_ff;
      res_status_in = res_status_ff;
      res_score_in  = res_score_ff;
      res_rank_in   = res_rank_ff;
      res_was_in    = res_was_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_was_in    = rsp_was_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IdxW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pos_ff[IdxW-1:0];
      wr_data       = '{key: key_ff, score: score_ff};

      case (state_ff)
         sst_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = req_ch.opcode;
               key_in   = req_ch.key;
               score_in = req_ch.score;
               idx_in   = '0;
               look_in  = 1'b0;
               case (req_ch.opcode)
                  sst_pkg::OpAdd, sst_pkg::OpRemove: begin
                     state_in = sst_pkg::S_FIND;
                  end
                  sst_pkg::OpRange: begin
                     if (range_empty) begin
                        res_status_in = sst_pkg::StEmpty;
                        res_score_in  = '0;
                        res_rank_in   = '0;
                        res_was_in    = 1'b0;
                        state_in      = sst_pkg::S_FINISH;
                     end else begin
                        idx_in   = CntW'(start_r);
                        stop_in  = CntW'(stop_r);
                        state_in = sst_pkg::S_RD_ISSUE;
                     end
                  end
                  default: begin
                     state_in = sst_pkg::S_IDLE;
                  end
               endcase
            end
         end

         // Scan for the key, one row a cycle
         sst_pkg::S_FIND: begin
            if (hit) begin
               pos_in        = idx_dn1;
               res_rank_in   = idx_dn1;
               res_was_in    = 1'b1;
               res_status_in = sst_pkg::StOk;
               look_in       = 1'b0;
               if (op_ff == sst_pkg::OpAdd) begin
                  res_score_in = score_ff;
                  state_in     = (rd_data_ff.score < score_ff) ? sst_pkg::S_UP
                                                               : sst_pkg::S_DOWN;
               end else begin
                  res_score_in = rd_data_ff.score;
                  state_in     = sst_pkg::S_DOWN;
               end
            end else if (idx_ff == fill_ff) begin
               res_was_in  = 1'b0;
               res_rank_in = '0;
               if (op_ff == sst_pkg::OpAdd) begin
                  if (fill_ff == CntW'(CAPACITY)) begin
                     res_status_in = sst_pkg::StFull;
                     res_score_in  = score_ff;
                     state_in      = sst_pkg::S_FINISH;
                  end else begin
                     res_status_in = sst_pkg::StOk;
                     res_score_in  = score_ff;
                     pos_in        = fill_ff;
                     fill_in       = fill_ff + CntW'(1);
                     look_in       = 1'b0;
                     state_in      = sst_pkg::S_UP;
                  end
               end else begin
                  res_status_in = sst_pkg::StNotFound;
                  res_score_in  = '0;
                  state_in      = sst_pkg::S_FINISH;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[IdxW-1:0];
               look_in = 1'b1;
               idx_in  = idx_ff + CntW'(1);
            end
         end

         // Move the hole up past strictly lower scores
         sst_pkg::S_UP: begin
            if (pos_ff == '0) begin
               wr_en       = 1'b1;
               res_rank_in = pos_ff;
               state_in    = sst_pkg::S_FINISH;
            end else if (!look_ff) begin
               rd_en   = 1'b1;
               rd_addr = pos_dn1[IdxW-1:0];
               look_in = 1'b1;
            end else if (score_ff > rd_data_ff.score) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = pos_dn1;
               if (pos_ff >= CntW'(2)) begin
                  rd_en   = 1'b1;
                  rd_addr = pos_dn2[IdxW-1:0];
                  look_in = 1'b1;
               end else begin
                  look_in = 1'b0;
               end
            end else begin
               wr_en       = 1'b1;
               res_rank_in = pos_ff;
               state_in    = sst_pkg::S_FINISH;
            end
         end

         // Move the hole down past higher scores, or close the gap on remove
         sst_pkg::S_DOWN: begin
            if (pos_up1 >= fill_w) begin
               if (op_ff == sst_pkg::OpAdd) begin
                  wr_en       = 1'b1;
                  res_rank_in = pos_ff;
               end else begin
                  fill_in = fill_ff - CntW'(1);
               end
               state_in = sst_pkg::S_FINISH;
            end else if (!look_ff) begin
               rd_en   = 1'b1;
               rd_addr = pos_up1[IdxW-1:0];
               look_in = 1'b1;
            end else if (move) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = pos_up1[CntW-1:0];
               if (pos_up2 < fill_w) begin
                  rd_en   = 1'b1;
                  rd_addr = pos_up2[IdxW-1:0];
                  look_in = 1'b1;
               end else begin
                  look_in = 1'b0;
               end
            end else begin
               wr_en       = 1'b1;
               res_rank_in = pos_ff;
               state_in    = sst_pkg::S_FINISH;
            end
         end

         // Hand the single result to the response register
         sst_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = key_ff;
               rsp_score_in  = res_score_ff;
               rsp_rank_in   = sst_pkg::RankW'(res_rank_ff);
               rsp_count_in  = sst_pkg::CountW'(fill_ff);
               rsp_was_in    = res_was_ff;
               rsp_last_in   = 1'b1;
               state_in      = sst_pkg::S_IDLE;
            end
         end

         sst_pkg::S_RD_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff[IdxW-1:0];
            state_in = sst_pkg::S_RD_LOAD;
         end

         // Emit one row of the range
         sst_pkg::S_RD_LOAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sst_pkg::StOk;
               rsp_key_in    = rd_data_ff.key;
               rsp_score_in  = rd_data_ff.score;
               rsp_rank_in   = sst_pkg::RankW'(idx_ff);
               rsp_count_in  = sst_pkg::CountW'(fill_ff);
               rsp_was_in    = 1'b0;
               rsp_last_in   = (idx_up1 == PW'(stop_ff));
               idx_in        = idx_up1[CntW-1:0];
               state_in      = (idx_up1 == PW'(stop_ff)) ? sst_pkg::S_IDLE
                                                         : sst_pkg::S_RD_ISSUE;
            end
         end

         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::S_IDLE;
         fill_ff      <= '0;
         look_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         look_ff      <= look_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      score_ff      <= score_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      stop_ff       <= stop_in;
      res_status_ff <= res_status_in;
      res_score_ff  <= res_score_in;
      res_rank_ff   <= res_rank_in;
      res_was_ff    <= res_was_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_was_ff    <= rsp_was_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Drive the response channel
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_key   = rsp_key_ff;
   assign rsp_ch.entry_score = rsp_score_ff;
   assign rsp_ch.rank        = rsp_rank_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.was_present = rsp_was_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/sst_checker.sv
`default_nettype none

module sst_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire [sst_pkg::OpW-1:0]           req_opcode,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [sst_pkg::StatW-1:0]         rsp_status,
   input wire [sst_pkg::KeyW-1:0]          rsp_entry_key,
   input wire [sst_pkg::ScoreW-1:0]        rsp_entry_score,
   input wire [sst_pkg::RankW-1:0]         rsp_rank,
   input wire [sst_pkg::CountW-1:0]        rsp_entry_count,
   input wire                              rsp_was_present,
   input wire                              rsp_last
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_key) && $stable(rsp_entry_score) && $stable(rsp_rank)
         && $stable(rsp_entry_count) && $stable(rsp_was_present) && $stable(rsp_last))
      else $error("stalled response changed");

   // Drop ready after taking a real operation
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == sst_pkg::OpAdd
         || req_opcode == sst_pkg::OpRemove || req_opcode == sst_pkg::OpRange)
      |=> !req_ready)
      else $error("ready right after an operation request");

   // Not-found and empty results carry no score, rank or presence flag, and are last
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sst_pkg::StNotFound || rsp_status == sst_pkg::StEmpty)
      |-> rsp_entry_score == '0 && rsp_rank == '0 && !rsp_was_present && rsp_last)
      else $error("miss result carries entry fields");

   // Only range rows come in multi-result bursts
   a_burst_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == sst_pkg::StOk && !rsp_was_present)
      else $error("non-final result is not a range row");

   // A held key always yields a single ok result
   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_present |-> rsp_status == sst_pkg::StOk && rsp_last)
      else $error("present key with bad status");

endmodule

bind sorted_score_table sst_checker u_sst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_opcode      (req_ch.opcode),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_entry_key   (rsp_ch.entry_key),
   .rsp_entry_score (rsp_ch.entry_score),
   .rsp_rank        (rsp_ch.rank),
   .rsp_entry_count (rsp_ch.entry_count),
   .rsp_was_present (rsp_ch.was_present),
   .rsp_last        (rsp_ch.last)
);

`default_nettype wire
